// ----- src/ppm_pkg.sv -----
// Shared types, codes and constants for the PPM P6 stream parser.
package ppm_pkg;

    localparam int MAX_DIM_DEF     = 4096;
    localparam int QUEUE_DEPTH_DEF = 4;
    // result buffer; power of two, pointers wrap naturally
    localparam int RES_DEPTH       = 4;

    localparam int SIZE_W = 13;
    localparam int RGB_W  = 24;
    localparam int MAXVAL = 255;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_SIX   = 8'h36;
    localparam logic [7:0] CH_HASH  = 8'h23;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;

    typedef enum logic [1:0] {
        KIND_PIXEL  = 2'd0,
        KIND_HEADER = 2'd1,
        KIND_BAD    = 2'd2,
        KIND_TRUNC  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        PH_MAGIC_P,
        PH_MAGIC_6,
        PH_BLANK,
        PH_COMMENT,
        PH_DIGITS,
        PH_PIXELS,
        PH_IDLE
    } phase_t;

    // classified input byte
    typedef struct packed {
        logic [7:0] data;
        logic       eos;
        logic       is_digit;
        logic       is_blank;
        logic       is_hash;
        logic       is_lf;
        logic       is_p;
        logic       is_six;
    } tok_t;

    typedef struct packed {
        kind_t             kind;
        logic [RGB_W-1:0]  rgb;
        logic              last;
        logic [SIZE_W-1:0] w;
        logic [SIZE_W-1:0] h;
    } res_t;

endpackage

// ----- src/ppm_p6_stream_parser.sv -----
// Top level of the PPM P6 stream parser.
//
//  channel | signals                                   | role
//  --------+-------------------------------------------+-------------------------------
//  in      | in_valid, in_ready, data_byte,            | one file byte per transfer
//          | end_of_stream                             |
//  out     | out_valid, out_ready, kind, pixel_rgb,    | pixel, header, error or
//          | last_pixel, image_width, image_height     | truncation result per transfer
//
// One byte per clock while the result buffer has room; a byte that yields two
// results (a pixel or header together with truncation) offers them as two transfers.
// A result passes the classify register, the token queue and the result buffer,
// in that order, before it is offered.
// Reset is asynchronous; no clearing pass, input taken as soon as reset is released.
// Either side may stall on its own; the token queue and result buffer absorb it.
module ppm_p6_stream_parser #(
    parameter int MAX_DIM     = ppm_pkg::MAX_DIM_DEF,
    parameter int QUEUE_DEPTH = ppm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [7:0]                 data_byte,
    input  logic                       end_of_stream,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 kind,
    output logic [ppm_pkg::RGB_W-1:0]  pixel_rgb,
    output logic                       last_pixel,
    output logic [ppm_pkg::SIZE_W-1:0] image_width,
    output logic [ppm_pkg::SIZE_W-1:0] image_height
);
    import ppm_pkg::*;

    tok_t front_tok, queue_tok;
    logic front_valid, front_ready;
    logic queue_valid, queue_ready;

    ppm_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .data_byte     (data_byte),
        .end_of_stream (end_of_stream),
        .tok           (front_tok),
        .tok_valid     (front_valid),
        .tok_ready     (front_ready)
    );

    ppm_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (front_valid),
        .push_ready (front_ready),
        .push_tok   (front_tok),
        .pop_valid  (queue_valid),
        .pop_ready  (queue_ready),
        .pop_tok    (queue_tok)
    );

    ppm_back #(
        .MAX_DIM (MAX_DIM)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .tok_valid    (queue_valid),
        .tok_ready    (queue_ready),
        .tok          (queue_tok),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .kind         (kind),
        .pixel_rgb    (pixel_rgb),
        .last_pixel   (last_pixel),
        .image_width  (image_width),
        .image_height (image_height)
    );

endmodule

// ----- src/ppm_front.sv -----
// Front end: takes input bytes and classifies them into tokens.
module ppm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [7:0]    data_byte,
    input  logic          end_of_stream,
    output ppm_pkg::tok_t tok,
    output logic          tok_valid,
    input  logic          tok_ready
);
    import ppm_pkg::*;

    logic tok_valid_reg, tok_valid_next;
    tok_t tok_reg, tok_next;
    logic accept;

    assign in_ready  = !tok_valid_reg || tok_ready;
    assign accept    = in_valid && in_ready;
    assign tok_valid = tok_valid_reg;
    assign tok       = tok_reg;

    always_comb
    begin
        tok_next          = tok_reg;
        tok_next.data     = data_byte;
        tok_next.eos      = end_of_stream;
        tok_next.is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
        tok_next.is_blank = (data_byte == CH_SPACE) || (data_byte == CH_TAB) ||
                            (data_byte == CH_LF) || (data_byte == CH_CR);
        tok_next.is_hash  = (data_byte == CH_HASH);
        tok_next.is_lf    = (data_byte == CH_LF);
        tok_next.is_p     = (data_byte == CH_P);
        tok_next.is_six   = (data_byte == CH_SIX);
        if (accept)
        begin
            tok_valid_next = 1'b1;
        end
        else if (tok_ready)
        begin
            tok_valid_next = 1'b0;
        end
        else
        begin
            tok_valid_next = tok_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tok_valid_reg <= 1'b0;
        end
        else
        begin
            tok_valid_reg <= tok_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            tok_reg <= tok_next;
        end
    end

endmodule

// ----- src/ppm_fifo.sv -----
// Token queue between the front end and the parser back end.
module ppm_fifo #(
    parameter int DEPTH = ppm_pkg::QUEUE_DEPTH_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push_valid,
    output logic          push_ready,
    input  ppm_pkg::tok_t push_tok,
    output logic          pop_valid,
    input  logic          pop_ready,
    output ppm_pkg::tok_t pop_tok
);
    import ppm_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    tok_t             mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             push, pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;
    assign pop_tok    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        count_next = count_reg + CNT_W'(push) - CNT_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_tok;
        end
    end

endmodule

// ----- src/ppm_back.sv -----
// Back end: header parser, pixel packer and result buffer.
module ppm_back #(
    parameter int MAX_DIM = ppm_pkg::MAX_DIM_DEF
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tok_valid,
    output logic                       tok_ready,
    input  ppm_pkg::tok_t              tok,
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [1:0]                 kind,
    output logic [ppm_pkg::RGB_W-1:0]  pixel_rgb,
    output logic                       last_pixel,
    output logic [ppm_pkg::SIZE_W-1:0] image_width,
    output logic [ppm_pkg::SIZE_W-1:0] image_height
);
    import ppm_pkg::*;

    localparam int SAT_CAP = ((MAX_DIM > MAXVAL) ? MAX_DIM : MAXVAL) + 1;
    localparam int ACC_W   = $clog2(SAT_CAP + 1);
    localparam int SUM_W   = ACC_W + 4;
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    localparam int MUL_W   = 2 * DIM_W;
    localparam int PL_W    = 2 * $clog2(MAX_DIM) + 1;
    localparam int RPTR_W  = $clog2(RES_DEPTH);
    localparam int RCNT_W  = $clog2(RES_DEPTH + 1);

    phase_t            phase_reg, phase_next;
    logic [1:0]        idx_reg, idx_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [ACC_W-1:0]  w_reg, w_next;
    logic [ACC_W-1:0]  h_reg, h_next;
    logic [1:0]        bip_reg, bip_next;
    logic [15:0]       part_reg, part_next;
    logic [PL_W-1:0]   pl_reg, pl_next;

    res_t              res_mem_reg [RES_DEPTH];
    logic [RPTR_W-1:0] rwr_reg, rwr_next, rwr_plus1;
    logic [RPTR_W-1:0] rrd_reg, rrd_next;
    logic [RCNT_W-1:0] rcnt_reg, rcnt_next;

    logic              step, pop;
    logic [SUM_W-1:0]  acc_sum;
    logic [ACC_W-1:0]  acc_sat, acc_dig, fin_val;
    logic              stay_digits, fin_main, fin_eos, fin, fin_hdr, hdr_ok;
    logic              bad_magic, pix_done, pix_last;
    logic [PL_W-1:0]   pl_dec;
    logic [MUL_W-1:0]  prod;
    phase_t            fin_phase, phase_mid, phase_end;
    logic              ev_valid, trunc;
    res_t              ev_res, trunc_res, res0;
    logic              push0, push1;
    res_t              head;

    // a step needs room for two results
    assign tok_ready = (rcnt_reg <= RCNT_W'(RES_DEPTH - 2));
    assign step      = tok_valid && tok_ready;

    // step decode
    always_comb
    begin
        acc_sum = SUM_W'({acc_reg, 3'b000}) + SUM_W'({acc_reg, 1'b0}) + SUM_W'(tok.data[3:0]);
        acc_sat = (acc_sum > SUM_W'(SAT_CAP)) ? ACC_W'(SAT_CAP) : acc_sum[ACC_W-1:0];
        acc_dig = (phase_reg == PH_BLANK) ? ACC_W'(tok.data[3:0]) : acc_sat;

        stay_digits = ((phase_reg == PH_BLANK) || (phase_reg == PH_DIGITS)) && tok.is_digit;
        fin_main    = ((phase_reg == PH_BLANK) && !tok.is_hash && !tok.is_blank &&
                       !tok.is_digit) ||
                      ((phase_reg == PH_DIGITS) && !tok.is_digit);
        fin_eos     = tok.eos && stay_digits;
        fin         = fin_main || fin_eos;
        fin_hdr     = fin && idx_reg[1];
        // a number with no digits reads as zero
        fin_val     = fin_eos ? acc_dig : ((phase_reg == PH_DIGITS) ? acc_reg : '0);

        hdr_ok = (w_reg != '0) && (h_reg != '0) &&
                 (w_reg <= ACC_W'(MAX_DIM)) && (h_reg <= ACC_W'(MAX_DIM)) &&
                 (fin_val == ACC_W'(MAXVAL));
        fin_phase = idx_reg[1] ? (hdr_ok ? PH_PIXELS : PH_IDLE) : PH_BLANK;

        bad_magic = ((phase_reg == PH_MAGIC_P) && !tok.is_p) ||
                    ((phase_reg == PH_MAGIC_6) && !tok.is_six);
        pix_done  = (phase_reg == PH_PIXELS) && (bip_reg == 2'd2);
        pl_dec    = (pl_reg == '0) ? '0 : pl_reg - 1'b1;
        pix_last  = (pl_dec == '0);
        prod      = MUL_W'(w_reg[DIM_W-1:0]) * MUL_W'(h_reg[DIM_W-1:0]);

        phase_mid = phase_reg;
        case (phase_reg)
            PH_MAGIC_P: phase_mid = tok.is_p ? PH_MAGIC_6 : PH_IDLE;
            PH_MAGIC_6: phase_mid = tok.is_six ? PH_BLANK : PH_IDLE;
            PH_BLANK:
            begin
                if (tok.is_hash)
                begin
                    phase_mid = PH_COMMENT;
                end
                else if (tok.is_digit)
                begin
                    phase_mid = PH_DIGITS;
                end
                else if (!tok.is_blank)
                begin
                    phase_mid = fin_phase;
                end
            end
            PH_COMMENT:
            begin
                if (tok.is_lf)
                begin
                    phase_mid = PH_BLANK;
                end
            end
            PH_DIGITS:
            begin
                if (!tok.is_digit)
                begin
                    phase_mid = fin_phase;
                end
            end
            PH_PIXELS:
            begin
                if (pix_done && pix_last)
                begin
                    phase_mid = PH_IDLE;
                end
            end
            default: phase_mid = phase_reg;
        endcase
        // end of stream inside digits closes the number first
        phase_end = fin_eos ? fin_phase : phase_mid;
        trunc     = tok.eos && (phase_end != PH_IDLE);
        ev_valid  = bad_magic || fin_hdr || pix_done;
    end

    // next state
    always_comb
    begin
        phase_next = phase_reg;
        idx_next   = idx_reg;
        acc_next   = acc_reg;
        w_next     = w_reg;
        h_next     = h_reg;
        bip_next   = bip_reg;
        part_next  = part_reg;
        pl_next    = pl_reg;
        if (step)
        begin
            phase_next = phase_end;
            if ((phase_reg == PH_MAGIC_6) && tok.is_six)
            begin
                idx_next = 2'd0;
                acc_next = '0;
            end
            if (stay_digits)
            begin
                acc_next = acc_dig;
            end
            if (fin)
            begin
                acc_next = '0;
                if (idx_reg == 2'd0)
                begin
                    w_next   = fin_val;
                    idx_next = 2'd1;
                end
                else if (idx_reg == 2'd1)
                begin
                    h_next   = fin_val;
                    idx_next = 2'd2;
                end
                else if (hdr_ok)
                begin
                    pl_next   = PL_W'(prod);
                    bip_next  = 2'd0;
                    part_next = '0;
                end
            end
            if (phase_reg == PH_PIXELS)
            begin
                if (pix_done)
                begin
                    bip_next  = 2'd0;
                    part_next = '0;
                    pl_next   = pl_dec;
                end
                else
                begin
                    bip_next  = bip_reg + 1'b1;
                    part_next = {part_reg[7:0], tok.data};
                end
            end
            if (tok.eos)
            begin
                phase_next = PH_MAGIC_P;
                idx_next   = 2'd0;
                acc_next   = '0;
                w_next     = '0;
                h_next     = '0;
                bip_next   = 2'd0;
                part_next  = '0;
                pl_next    = '0;
            end
        end
    end

    // result generation and buffer control
    always_comb
    begin
        ev_res      = '0;
        trunc_res   = '0;
        trunc_res.kind = KIND_TRUNC;
        if (bad_magic)
        begin
            ev_res.kind = KIND_BAD;
        end
        else if (fin_hdr)
        begin
            ev_res.kind = hdr_ok ? KIND_HEADER : KIND_BAD;
            if (hdr_ok)
            begin
                ev_res.w = SIZE_W'(w_reg);
                ev_res.h = SIZE_W'(h_reg);
            end
        end
        else
        begin
            ev_res.kind = KIND_PIXEL;
            ev_res.rgb  = {part_reg, tok.data};
            ev_res.last = pix_last;
        end
        res0      = ev_valid ? ev_res : trunc_res;
        push0     = step && (ev_valid || trunc);
        push1     = step && ev_valid && trunc;
        rwr_plus1 = rwr_reg + 1'b1;
        rwr_next  = rwr_reg + RPTR_W'(push0) + RPTR_W'(push1);
        rrd_next  = rrd_reg + RPTR_W'(pop);
        rcnt_next = rcnt_reg + RCNT_W'(push0) + RCNT_W'(push1) - RCNT_W'(pop);
    end

    assign head         = res_mem_reg[rrd_reg];
    assign out_valid    = (rcnt_reg != '0);
    assign pop          = out_valid && out_ready;
    assign kind         = head.kind;
    assign pixel_rgb    = head.rgb;
    assign last_pixel   = head.last;
    assign image_width  = head.w;
    assign image_height = head.h;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_MAGIC_P;
            idx_reg   <= 2'd0;
            acc_reg   <= '0;
            w_reg     <= '0;
            h_reg     <= '0;
            bip_reg   <= 2'd0;
            part_reg  <= '0;
            pl_reg    <= '0;
            rwr_reg   <= '0;
            rrd_reg   <= '0;
            rcnt_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            idx_reg   <= idx_next;
            acc_reg   <= acc_next;
            w_reg     <= w_next;
            h_reg     <= h_next;
            bip_reg   <= bip_next;
            part_reg  <= part_next;
            pl_reg    <= pl_next;
            rwr_reg   <= rwr_next;
            rrd_reg   <= rrd_next;
            rcnt_reg  <= rcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push0)
        begin
            res_mem_reg[rwr_reg] <= res0;
        end
        if (push1)
        begin
            res_mem_reg[rwr_plus1] <= trunc_res;
        end
    end

endmodule

// ----- src/ppm_checker.sv -----
// Port-level checks for the PPM P6 stream parser, bound to the top level.
module ppm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [1:0]                 kind,
    input logic [ppm_pkg::RGB_W-1:0]  pixel_rgb,
    input logic                       last_pixel,
    input logic [ppm_pkg::SIZE_W-1:0] image_width,
    input logic [ppm_pkg::SIZE_W-1:0] image_height
);
    import ppm_pkg::*;

    // nothing is offered while reset is held
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result offered during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(pixel_rgb) &&
        $stable(last_pixel) && $stable(image_width) && $stable(image_height))
        else $error("stalled result changed");

    a_non_pixel_clear: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_PIXEL) |-> (pixel_rgb == '0) && !last_pixel)
        else $error("pixel fields set on non-pixel result");

    a_sizes_only_header: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind != KIND_HEADER) |-> (image_width == '0) && (image_height == '0))
        else $error("sizes set outside header result");

    a_header_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (kind == KIND_HEADER) |-> (image_width != '0) && (image_height != '0))
        else $error("header accepted with zero size");

endmodule

bind ppm_p6_stream_parser ppm_checker u_ppm_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .kind          (kind),
    .pixel_rgb     (pixel_rgb),
    .last_pixel    (last_pixel),
    .image_width   (image_width),
    .image_height  (image_height)
);
